// ----- rtl/core/cicmd_pkg.sv -----
// cicmd_pkg: grid geometry, action and register codes, fixed-point helpers
// for the cloud-in-cell mass deposit block
// no dependencies
package cicmd_pkg;

  // grid edge length in cells, periodic in all three axes
  localparam int GRID_DIM   = 32;
  localparam int IDX_W      = $clog2(GRID_DIM);
  localparam int PLANE      = GRID_DIM * GRID_DIM;
  localparam int CELLS      = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int ADDR_W     = $clog2(CELLS);

  localparam int POS_W      = 32;
  localparam int REG_W      = 32;
  localparam int COORD_W    = 5;
  localparam int DENS_W     = 48;
  localparam int WGT_W      = 17;   // Q0.16 weight, holds 1.0 exactly
  localparam int FRAC_W     = 16;
  localparam int AMT_W      = 33;   // rounded mass * weight, Q17.16

  localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

  typedef enum logic [1:0] {
    ACT_DEPOSIT    = 2'd0,
    ACT_READ       = 2'd1,
    ACT_READ_CLEAR = 2'd2,
    ACT_NONE       = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    CFG_MASS_WEIGHT = 1'b0,
    CFG_CELL_SCALE  = 1'b1
  } cfg_reg_t;

  // true when a coordinate lies on the grid
  function automatic logic in_grid(input logic [POS_W-1:0] v);
    return v < POS_W'(GRID_DIM);
  endfunction

  // linear cell address, x major, z minor
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] y,
                                                  input logic [IDX_W-1:0] z);
    return ADDR_W'(ADDR_W'(x) * ADDR_W'(PLANE) + ADDR_W'(y) * ADDR_W'(GRID_DIM)
                   + ADDR_W'(z));
  endfunction

  // upper neighbour with wrap at the grid edge
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(GRID_DIM - 1)) ? '0 : IDX_W'(i + 1'b1);
  endfunction

  // (a * b + half) >> 16 for two Q0.16 weights
  function automatic logic [WGT_W-1:0] mul_q16(input logic [WGT_W-1:0] a,
                                               input logic [WGT_W-1:0] b);
    logic [2*WGT_W-1:0] p;
    p = (2*WGT_W)'(a) * (2*WGT_W)'(b) + (2*WGT_W)'(32768);
    return p[FRAC_W +: WGT_W];
  endfunction

endpackage

// ----- rtl/core/cicmd_ram.sv -----
// cicmd_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module cicmd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/cloud_in_cell_mass_deposit.sv -----
// cloud_in_cell_mass_deposit: cloud-in-cell mass deposit onto a periodic 3-d
// density grid held in one ram; depends on cicmd_pkg and cicmd_ram
//
// deposit: busy from accept to the next possible accept through
//   3 shared 32x32 position multiplies, then 8 read-modify-write
//   beats, one cell per cycle, through the s1, s2, s3 weight pipeline;
//   a deposit outside the grid frees the block at the end of its split
// a read beat passes S_READ and S_READ_DATA, then shows its result on out_valid and the
//   block takes the next beat in that same cycle; the receiver cannot stall
// unused action code: accepted with no effect
// reset: synchronous, active low; registers return to defaults and busy stays
//   high for a clearing pass that zeroes all GRID_DIM^3 (32768) cells of the grid;
//   configuration writes are taken during the pass
module cloud_in_cell_mass_deposit
  import cicmd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_action,
  input  logic [POS_W-1:0]    in_pos_x,
  input  logic [POS_W-1:0]    in_pos_y,
  input  logic [POS_W-1:0]    in_pos_z,
  input  logic [COORD_W-1:0]  in_cell_x,
  input  logic [COORD_W-1:0]  in_cell_y,
  input  logic [COORD_W-1:0]  in_cell_z,
  // result channel
  output logic                out_valid,
  output logic [DENS_W-1:0]   out_cell_density,
  // configuration
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [REG_W-1:0]    cfg_wdata
);

  // corner beats issue on counts 0..7, the last write lands on count 10
  localparam int CNT_W       = 4;
  localparam int CORNER_DONE = 10;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SPLIT,
    S_CORNER,
    S_READ,
    S_READ_DATA
  } state_t;

  state_t              state_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [1:0]          ax_cnt_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                s1_v_r, s2_v_r, s3_v_r;
  logic                out_valid_r;
  logic [REG_W-1:0]    mass_r;
  logic [REG_W-1:0]    scale_r;

  // payload registers
  logic [POS_W-1:0]    pos_x_r, pos_y_r, pos_z_r;
  logic [ADDR_W-1:0]   rd_addr_r;
  logic                rd_ok_r;
  logic                rd_clr_r;
  logic [2*POS_W-1:0]  mul_r;
  logic [IDX_W-1:0]    ix_r, iy_r, iz_r;
  logic [FRAC_W-1:0]   fx_r, fy_r, fz_r;
  logic                ox_r, oy_r;
  logic [WGT_W-1:0]    s1_wxy_r, s1_wz_r;
  logic [ADDR_W-1:0]   s1_addr_r, s2_addr_r, s3_addr_r;
  logic [WGT_W-1:0]    s2_w_r;
  logic [AMT_W-1:0]    s3_amt_r;
  logic [DENS_W-1:0]   out_dens_r;

  logic                accept;
  action_t             act;
  logic                z_out;
  logic [POS_W-1:0]    pos_sel;
  logic                issue;
  logic [2:0]          corner;
  logic [WGT_W-1:0]    wx, wy, wz;
  logic [IDX_W-1:0]    cx, cy, cz;
  logic [2*REG_W:0]    amt_full;
  logic [DENS_W:0]     acc_sum;

  // ram ports
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [DENS_W-1:0]   ram_wdata, ram_rdata;

  assign busy             = (state_r != S_IDLE);
  assign accept           = start && !busy;
  assign act              = action_t'(in_action);
  assign out_valid        = out_valid_r;
  assign out_cell_density = out_dens_r;

  // z axis comes straight off the multiplier on the last split cycle
  assign z_out = !in_grid(mul_r[2*POS_W-1:POS_W]);

  // shared multiplier operand, one axis per cycle
  always_comb begin
    unique case (ax_cnt_r)
      2'd0:    pos_sel = pos_x_r;
      2'd1:    pos_sel = pos_y_r;
      default: pos_sel = pos_z_r;
    endcase
  end

  // corner selection: bit 2 picks the x neighbour, bit 1 y, bit 0 z
  assign issue  = (state_r == S_CORNER) && !cnt_r[CNT_W-1];
  assign corner = cnt_r[2:0];
  assign wx = corner[2] ? WGT_W'(fx_r) : WGT_W'(ONE_Q16 - WGT_W'(fx_r));
  assign wy = corner[1] ? WGT_W'(fy_r) : WGT_W'(ONE_Q16 - WGT_W'(fy_r));
  assign wz = corner[0] ? WGT_W'(fz_r) : WGT_W'(ONE_Q16 - WGT_W'(fz_r));
  assign cx = corner[2] ? next_idx(ix_r) : ix_r;
  assign cy = corner[1] ? next_idx(iy_r) : iy_r;
  assign cz = corner[0] ? next_idx(iz_r) : iz_r;

  // mass * weight with round half up, at most 49 significant bits
  assign amt_full = (2*REG_W+1)'(mass_r) * (2*REG_W+1)'(s2_w_r) + (2*REG_W+1)'(32768);

  // accumulate with saturation at the top of the 48-bit range
  assign acc_sum = (DENS_W+1)'(ram_rdata) + (DENS_W+1)'(s3_amt_r);

  // ram access: read on stage 2 or the read beat, write on stage 3,
  // on the clearing pass, or when a read-and-clear finishes
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = s2_addr_r;
    ram_we    = 1'b0;
    ram_waddr = s3_addr_r;
    ram_wdata = acc_sum[DENS_W] ? {DENS_W{1'b1}} : acc_sum[DENS_W-1:0];
    priority case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_READ: begin
        ram_re    = rd_ok_r;
        ram_raddr = rd_addr_r;
      end
      S_READ_DATA: begin
        ram_we    = rd_ok_r && rd_clr_r;
        ram_waddr = rd_addr_r;
        ram_wdata = '0;
      end
      S_CORNER: begin
        ram_re = s2_v_r;
        ram_we = s3_v_r;
      end
      default: begin
        ram_re = 1'b0;
        ram_we = 1'b0;
      end
    endcase
  end

  cicmd_ram #(
    .WIDTH (DENS_W),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control: state, counters, pipeline valids, result strobe, registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      ax_cnt_r    <= '0;
      cnt_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mass_r      <= REG_W'(65536);
      scale_r     <= REG_W'(65536);
    end else begin
      out_valid_r <= 1'b0;
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_MASS_WEIGHT: mass_r  <= cfg_wdata;
          CFG_CELL_SCALE:  scale_r <= cfg_wdata;
        endcase
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= ADDR_W'(clr_cnt_r + 1'b1);
          if (clr_cnt_r == ADDR_W'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (act)
              ACT_DEPOSIT: begin
                state_r  <= S_SPLIT;
                ax_cnt_r <= '0;
              end
              ACT_READ, ACT_READ_CLEAR: state_r <= S_READ;
              ACT_NONE:                 state_r <= S_IDLE;
            endcase
          end
        end
        S_SPLIT: begin
          ax_cnt_r <= ax_cnt_r + 2'd1;
          if (ax_cnt_r == 2'd3) begin
            // particle off the grid leaves the grid untouched
            if (ox_r || oy_r || z_out) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_CORNER;
              cnt_r   <= '0;
            end
          end
        end
        S_CORNER: begin
          cnt_r <= CNT_W'(cnt_r + 1'b1);
          if (cnt_r == CNT_W'(CORNER_DONE)) begin
            state_r <= S_IDLE;
          end
        end
        S_READ: begin
          state_r <= S_READ_DATA;
        end
        S_READ_DATA: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_x_r   <= in_pos_x;
      pos_y_r   <= in_pos_y;
      pos_z_r   <= in_pos_z;
      rd_ok_r   <= in_grid(POS_W'(in_cell_x)) && in_grid(POS_W'(in_cell_y))
                   && in_grid(POS_W'(in_cell_z));
      rd_clr_r  <= (act == ACT_READ_CLEAR);
      rd_addr_r <= cell_addr(IDX_W'(in_cell_x), IDX_W'(in_cell_y), IDX_W'(in_cell_z));
    end

    // split: position * scale in q32.32, index above bit 32, fraction below
    if (state_r == S_SPLIT) begin
      if (ax_cnt_r != 2'd3) begin
        mul_r <= (2*POS_W)'(pos_sel) * (2*POS_W)'(scale_r);
      end
      unique case (ax_cnt_r)
        2'd1: begin
          ix_r <= mul_r[POS_W +: IDX_W];
          fx_r <= mul_r[FRAC_W +: FRAC_W];
          ox_r <= !in_grid(mul_r[2*POS_W-1:POS_W]);
        end
        2'd2: begin
          iy_r <= mul_r[POS_W +: IDX_W];
          fy_r <= mul_r[FRAC_W +: FRAC_W];
          oy_r <= !in_grid(mul_r[2*POS_W-1:POS_W]);
        end
        2'd3: begin
          iz_r <= mul_r[POS_W +: IDX_W];
          fz_r <= mul_r[FRAC_W +: FRAC_W];
        end
        default: begin
        end
      endcase
    end

    // weight pipeline: wx*wy, then *wz, then *mass
    s1_wxy_r  <= mul_q16(wx, wy);
    s1_wz_r   <= wz;
    s1_addr_r <= cell_addr(cx, cy, cz);
    s2_w_r    <= mul_q16(s1_wxy_r, s1_wz_r);
    s2_addr_r <= s1_addr_r;
    s3_amt_r  <= amt_full[FRAC_W +: AMT_W];
    s3_addr_r <= s2_addr_r;

    if (state_r == S_READ_DATA) begin
      out_dens_r <= rd_ok_r ? ram_rdata : '0;
    end
  end

  // a result strobe only follows the read data cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_READ_DATA))
    else $error("result strobe without a read beat");

  // the eight corners of one deposit never read and write the same cell at once
  assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ram read and write collide on one cell");

  // one strobe per read beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking bench for the cloud-in-cell mass deposit block
// depends on cicmd_pkg and cloud_in_cell_mass_deposit; keeps its own copy of the grid
module tb_top
  import cicmd_pkg::*;
;

  localparam int unsigned QUIET_LIMIT   = 200000;  // idle cycles before giving up
  localparam int unsigned SETTLE_TICKS  = 24;      // longer than one deposit
  localparam int unsigned PILE_DEPOSITS = 48;      // full-mass beats stacked on one cell
  localparam int unsigned PHASE_ITEMS   = 80;
  localparam bit [63:0]   DENS_MAX      = (64'd1 << DENS_W) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // command side
  logic               start = 1'b0;
  logic               busy;
  action_t            in_action = ACT_NONE;
  logic [POS_W-1:0]   in_pos_x = '0;
  logic [POS_W-1:0]   in_pos_y = '0;
  logic [POS_W-1:0]   in_pos_z = '0;
  logic [COORD_W-1:0] in_cell_x = '0;
  logic [COORD_W-1:0] in_cell_y = '0;
  logic [COORD_W-1:0] in_cell_z = '0;

  // result side
  logic              out_valid;
  logic [DENS_W-1:0] out_cell_density;

  // register port
  logic             cfg_we = 1'b0;
  cfg_reg_t         cfg_index = CFG_MASS_WEIGHT;
  logic [REG_W-1:0] cfg_wdata = '0;

  // shadow state of the block
  bit [DENS_W-1:0]   density_model [CELLS];
  bit [REG_W-1:0]    mass_q16 = 32'h0001_0000;
  bit [REG_W-1:0]    scale_q16 = 32'h0001_0000;
  bit [DENS_W-1:0]   density_expected [$];
  bit [COORD_W-1:0]  hot_x, hot_y, hot_z;     // last cell that took mass

  bit gaps_on = 1'b1;
  int unsigned n_deposits, n_reads, n_checked, n_errors, n_settings;
  int unsigned quiet_ticks;

  cloud_in_cell_mass_deposit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .in_cell_z        (in_cell_z),
    .out_valid        (out_valid),
    .out_cell_density (out_cell_density),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // world position to cell index and q0.16 fraction, exact 64-bit product
  function automatic void split_axis_q(input bit [31:0] pos, output bit [31:0] idx,
                                       output bit [16:0] frac);
    bit [63:0] p;
    p = 64'(pos) * 64'(scale_q16);
    idx = p[63:32];
    frac = {1'b0, p[31:16]};
  endfunction

  // spread one particle over its eight neighbors, clipping each cell at full scale
  function automatic void deposit_mass(input bit [31:0] px, input bit [31:0] py,
                                       input bit [31:0] pz);
    bit [31:0] ix, iy, iz;
    bit [16:0] fx, fy, fz;
    bit [COORD_W-1:0] cx [2];
    bit [COORD_W-1:0] cy [2];
    bit [COORD_W-1:0] cz [2];
    bit [16:0] wx [2];
    bit [16:0] wy [2];
    bit [16:0] wz [2];
    bit [63:0] wxy, w, amt, sum;
    int unsigned slot;
    split_axis_q(px, ix, fx);
    split_axis_q(py, iy, fy);
    split_axis_q(pz, iz, fz);
    // particle off the grid leaves everything alone
    if (ix >= GRID_DIM || iy >= GRID_DIM || iz >= GRID_DIM) return;
    hot_x = ix[COORD_W-1:0];
    hot_y = iy[COORD_W-1:0];
    hot_z = iz[COORD_W-1:0];
    // upper neighbor wraps around the periodic edge
    cx[0] = ix[COORD_W-1:0];
    cy[0] = iy[COORD_W-1:0];
    cz[0] = iz[COORD_W-1:0];
    cx[1] = (ix == GRID_DIM - 1) ? '0 : COORD_W'(ix + 1);
    cy[1] = (iy == GRID_DIM - 1) ? '0 : COORD_W'(iy + 1);
    cz[1] = (iz == GRID_DIM - 1) ? '0 : COORD_W'(iz + 1);
    wx[0] = 17'd65536 - fx;  wx[1] = fx;
    wy[0] = 17'd65536 - fy;  wy[1] = fy;
    wz[0] = 17'd65536 - fz;  wz[1] = fz;
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        for (int c = 0; c < 2; c++) begin
          // round half up after each product
          wxy = (64'(wx[a]) * 64'(wy[b]) + 64'd32768) >> 16;
          w   = (wxy * 64'(wz[c]) + 64'd32768) >> 16;
          amt = (64'(mass_q16) * w + 64'd32768) >> 16;
          slot = (int'(cx[a]) * GRID_DIM + int'(cy[b])) * GRID_DIM + int'(cz[c]);
          sum = 64'(density_model[slot]) + amt;
          density_model[slot] = (sum > DENS_MAX) ? DENS_MAX[DENS_W-1:0] : sum[DENS_W-1:0];
        end
  endfunction

  function automatic bit [DENS_W-1:0] fetch_density(input bit [COORD_W-1:0] x,
                                                    input bit [COORD_W-1:0] y,
                                                    input bit [COORD_W-1:0] z,
                                                    input bit clear);
    int unsigned slot;
    bit [DENS_W-1:0] v;
    slot = (int'(x) * GRID_DIM + int'(y)) * GRID_DIM + int'(z);
    v = density_model[slot];
    if (clear) density_model[slot] = '0;
    return v;
  endfunction

  // position that lands on the grid under the current scale, or at most on its upper edge
  function automatic bit [31:0] pick_pos();
    bit [63:0] lim;
    if (scale_q16 == 0) return $urandom;
    lim = (64'd32 << 32) / 64'(scale_q16);
    if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
    return $urandom_range(0, lim[31:0]);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus plumbing
  // ---------------------------------------------------------------------------

  // present one beat, hold it until taken, then maybe idle a while;
  // start stays high on a zero gap so the next beat follows back to back
  task automatic send_beat(input action_t act, input bit [31:0] px, input bit [31:0] py,
                           input bit [31:0] pz, input bit [COORD_W-1:0] x,
                           input bit [COORD_W-1:0] y, input bit [COORD_W-1:0] z);
    int unsigned gap;
    start     <= 1'b1;
    in_action <= act;
    in_pos_x  <= px;
    in_pos_y  <= py;
    in_pos_z  <= pz;
    in_cell_x <= x;
    in_cell_y <= y;
    in_cell_z <= z;
    do @(posedge clk); while (busy !== 1'b0);
    case (act)
      ACT_DEPOSIT: begin
        deposit_mass(px, py, pz);
        n_deposits++;
      end
      ACT_READ, ACT_READ_CLEAR: begin
        density_expected = {density_expected,
                            fetch_density(x, y, z, act == ACT_READ_CLEAR)};
        n_reads++;
      end
      default: ;  // unused code, block ignores it
    endcase
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // cell fields are don't-care on a deposit, so they carry noise
  task automatic deposit(input bit [31:0] px, input bit [31:0] py, input bit [31:0] pz);
    send_beat(ACT_DEPOSIT, px, py, pz, COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom));
  endtask

  task automatic read_cell(input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y,
                           input bit [COORD_W-1:0] z, input bit clear);
    send_beat(clear ? ACT_READ_CLEAR : ACT_READ, $urandom, $urandom, $urandom, x, y, z);
  endtask

  // sender stops until every density is back and the last deposit has retired
  task automatic drain_results();
    start <= 1'b0;
    while (density_expected.size() > 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // both registers in consecutive cycles, only while the block is idle
  task automatic set_config(input bit [31:0] mass, input bit [31:0] scale);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MASS_WEIGHT;
    cfg_wdata <= mass;
    @(posedge clk);
    mass_q16 = mass;
    cfg_index <= CFG_CELL_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    scale_q16 = scale;
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // checking and watchdog
  // ---------------------------------------------------------------------------

  // every strobe is matched against the oldest predicted density
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (density_expected.size() == 0) begin
        $error("cell_density: unexpected result %0h with nothing pending", out_cell_density);
        n_errors++;
      end else begin
        bit [DENS_W-1:0] want;
        want = density_expected.pop_front();
        n_checked++;
        if (out_cell_density !== want) begin
          $error("cell_density mismatch: expected %0h, got %0h", want, out_cell_density);
          n_errors++;
        end
      end
    end
  end

  // counts cycles where neither a command nor a result moves
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || cfg_we)
      quiet_ticks <= 0;
    else
      quiet_ticks <= quiet_ticks + 1;
    if (quiet_ticks >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_ticks);
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // default registers: exact cells, edge wrap, off-grid skips, ignored code, clearing reads
  task automatic test_directed_cases();
    read_cell(0, 0, 0, 1'b0);                                  // empty after clearing pass
    deposit(32'h0, 32'h0, 32'h0);                              // whole mass on one cell
    deposit(32'h001F_8000, 32'h0001_4000, 32'h000F_FFFF);      // x neighbor wraps to 0
    deposit(32'h001F_C000, 32'h001F_0001, 32'h001F_FFFF);      // all axes wrap
    deposit(32'h0020_0000, 32'h0, 32'h0);                      // x just off the grid
    deposit(32'h0, 32'h0020_0000, 32'h0);
    deposit(32'h0, 32'h0, 32'h0020_0000);
    deposit(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);      // far off the grid
    send_beat(ACT_NONE, $urandom, $urandom, $urandom, COORD_W'($urandom),
              COORD_W'($urandom), COORD_W'($urandom));
    read_cell(0, 0, 0, 1'b0);
    read_cell(31, 1, 15, 1'b0);
    read_cell(0, 1, 15, 1'b0);
    read_cell(31, 31, 31, 1'b0);
    read_cell(0, 0, 31, 1'b0);
    read_cell(31, 0, 0, 1'b0);
    read_cell(0, 0, 0, 1'b1);
    read_cell(0, 0, 0, 1'b0);                                  // cleared
    read_cell(31, 31, 31, 1'b1);
    read_cell(31, 31, 31, 1'b0);
    drain_results();
  endtask

  // register corners: zero, full and smallest mass, zero, unit, full and smallest scale
  task automatic test_register_extremes();
    set_config(32'hFFFF_FFFF, 32'h0);          // every particle collapses onto the origin
    for (int i = 0; i < 4; i++) deposit($urandom, $urandom, $urandom);
    read_cell(0, 0, 0, 1'b0);
    read_cell(1, 0, 0, 1'b0);
    set_config(32'h0, 32'h0001_0000);          // massless particles
    deposit(32'h0003_8000, 32'h0004_8000, 32'h0005_8000);
    read_cell(3, 4, 5, 1'b0);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // largest scale, tiny world
    deposit(32'h1F, 32'h20, 32'h0);
    deposit(32'h21, 32'h0, 32'h0);             // one step past the edge
    read_cell(30, 31, 0, 1'b1);
    read_cell(31, 0, 0, 1'b1);
    set_config(32'h1, 32'h1);                  // smallest nonzero values
    deposit(32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
    read_cell(0, 0, 0, 1'b1);
    read_cell(1, 0, 1, 1'b0);
    drain_results();
  endtask

  // back-to-back full-mass particles on one cell build a large sum
  task automatic test_pileup();
    set_config(32'hFFFF_FFFF, 32'h0001_0000);
    read_cell(0, 0, 0, 1'b1);
    gaps_on = 1'b0;
    for (int unsigned i = 0; i < PILE_DEPOSITS; i++) deposit(32'h0, 32'h0, 32'h0);
    gaps_on = 1'b1;
    read_cell(0, 0, 0, 1'b0);
    read_cell(0, 0, 0, 1'b1);
    read_cell(0, 0, 0, 1'b0);
    drain_results();
  endtask

  // mostly on-grid deposits with reads, half around the last hit cell, some noise
  task automatic test_random_traffic();
    bit [31:0] masses [6];
    bit [31:0] scales [6];
    int unsigned roll, sent;
    masses = '{32'h0001_0000, $urandom, $urandom_range(0, 32'h0010_0000),
               32'hFFFF_FFFF, $urandom, $urandom};
    scales = '{32'h0001_0000, 32'h0001_0000, $urandom_range(2048, 32'h0010_0000),
               32'hFFFF_FFFF, 32'h1, $urandom_range(32'h0002_0000, 32'h0100_0000)};
    foreach (masses[p]) begin
      set_config(masses[p], scales[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (sent % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          deposit(pick_pos(), pick_pos(), pick_pos());
          sent++;
        end else if (roll < 62) begin
          deposit($urandom, $urandom, $urandom);
          sent++;
        end else if (roll < 96) begin
          // half the reads hit the neighborhood of the last deposit
          if ($urandom_range(0, 1))
            read_cell(COORD_W'(hot_x + $urandom_range(0, 1)),
                      COORD_W'(hot_y + $urandom_range(0, 1)),
                      COORD_W'(hot_z + $urandom_range(0, 1)), roll >= 88);
          else
            read_cell(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      roll >= 88);
          sent++;
        end else begin
          send_beat(ACT_NONE, $urandom, $urandom, $urandom, COORD_W'($urandom),
                    COORD_W'($urandom), COORD_W'($urandom));
        end
        if ($urandom_range(0, 99) < 3) drain_results();
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    drain_results();  // wait out the clearing pass
    test_directed_cases();
    test_register_extremes();
    test_pileup();
    test_random_traffic();
    drain_results();
    $display("covered %0d deposits and %0d cell reads over %0d register settings",
             n_deposits, n_reads, n_settings);
    $display("%0d densities compared, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0 && density_expected.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
